/* src/fsts_pkg.sv */
`default_nettype none
package fsts_pkg;
   localparam int unsigned IdWidth    = 16;
   localparam int unsigned NiceWidth  = 6;
   localparam int unsigned NeedWidth  = 16;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam logic [TimeWidth-1:0] Sat32 = '1;
   localparam logic [5:0] NiceOffset  = 6'd21;
   localparam logic [5:0] NiceDivisor = 6'd39;
   // floor(x / 39) equals (x * NiceRecip) >> NiceRecipShift for any x below 2^22
   localparam logic [22:0] NiceRecip = 23'd6882961;
   localparam int unsigned NiceRecipShift = 28;
   localparam logic [CfgWidth-1:0] ResetTimeSlice = 16'd2000;
   localparam logic [CfgWidth-1:0] ResetMinGran   = 16'd4;

   localparam logic RegTimeSlice = 1'b0;
   localparam logic RegMinGran   = 1'b1;

   localparam logic OpAdd  = 1'b0;
   localparam logic OpPick = 1'b1;

   typedef struct packed {
      logic [IdWidth-1:0]   id;
      logic [NiceWidth-1:0] nice;
      logic [NeedWidth-1:0] need;
      logic [TimeWidth-1:0] vt;
      logic [TimeWidth-1:0] rt;
      logic [TimeWidth-1:0] order;
   } task_type;

   // one entry traveling down the row of cells
   typedef struct packed {
      logic     valid;
      task_type rec;
   } slot_type;

   // command broadcast to every cell
   typedef struct packed {
      logic     load;   // not read by the cells; a task enters at the head of the row via fill
      task_type rec;
      logic     del;    // drop the entry matching del_order
      logic [TimeWidth-1:0] del_order;
      logic     rotate; // shift one step around the ring
   } cmd_type;
endpackage
`default_nettype wire

/* src/fsts_cell.sv */
`default_nettype none
module fsts_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fsts_pkg::cmd_type     cmd,
   input  wire fsts_pkg::slot_type    prev_slot,
   output fsts_pkg::slot_type         slot
);
   logic     valid_ff, valid_in;
   fsts_pkg::task_type rec_ff, rec_in;

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (cmd.rotate) begin
         valid_in = prev_slot.valid;
         rec_in   = prev_slot.rec;
      end else if (cmd.del && valid_ff && rec_ff.order == cmd.del_order) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      rec_ff <= rec_in;
   end

   assign slot.valid = valid_ff;
   assign slot.rec   = rec_ff;
endmodule
`default_nettype wire

/* src/fsts_divider.sv */
`default_nettype none
module fsts_divider #(
   parameter int unsigned NumWidth = 16,
   parameter int unsigned DenWidth = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NumWidth-1:0] num,
   input  wire logic [DenWidth-1:0] den,
   output logic                     done,
   output logic [NumWidth-1:0]      quot
);
   localparam int unsigned CntWidth = $clog2(NumWidth + 1);
   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CntWidth'(NumWidth); busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division, one quotient bit per cycle
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   // a zero divisor yields all ones; the caller never starts a division with a zero count
   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

/* src/fair_share_task_scheduler_unit.sv */
`default_nettype none
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | req_tdata, req_tuser = operation
// rsp     | out | rsp_tvalid/tready   | rsp_tdata
// csr     | in  | csr_valid/csr_ready | csr_index, csr_data
// A result appears after these steps, once its transaction is accepted:
// one lap of the row finds minimum, count, best and a free cell,
// up to a second lap places a task, then a pick does a 16-step quantum division,
// the nice weight multiply, the divide by 39 and the saturating sums.
// Reset clears all cell valid bits, counters and the running task at once.
// One item is in work at a time; a held result stalls the next item only when
// that item's result is ready.
module fair_share_task_scheduler_unit #(
   parameter int unsigned MAX_TASKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // nice[5:0], cpu_needed[21:6], task_id[37:22]
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,  // add_rejected, run_valid, run_id[17:2],
                                        // quantum[33:18], finished_valid[34], finished_id[50:35]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int unsigned CntWidth = $clog2(MAX_TASKS + 2);
   localparam int unsigned TW = fsts_pkg::TimeWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_ADD, S_PICK, S_DIV, S_WAITQ, S_MUL, S_DIVV, S_WAITV, S_DONE
   } state_type;
   state_type state_ff, state_in;

   logic [15:0] ts_ff, mg_ff;
   logic [TW-1:0] ictr_ff, ictr_in;
   logic run_ff, run_in;
   fsts_pkg::task_type rt_ff, rt_in;
   logic op_ff;
   logic [5:0] nice_ff;
   logic [15:0] need_ff, id_ff;
   logic [CntWidth-1:0] step_ff, step_in, n_ff, n_in;
   logic any_ff, any_in, free_ff, free_in;
   logic [TW-1:0] minv_ff, minv_in;
   fsts_pkg::task_type best_ff, best_in;
   logic back_ff, back_in, fin_ff, fin_in;
   logic [15:0] q_ff, q_in;
   logic [21:0] prod_ff, prod_in;
   logic [16:0] dv_ff, dv_in;
   logic [44:0] dv_prod;
   logic [55:0] out_ff, out_in;
   logic [55:0] rsp_ff, rsp_in;
   logic outv_ff, outv_in;

   fsts_pkg::cmd_type  cmd;
   fsts_pkg::slot_type slots [MAX_TASKS];
   fsts_pkg::slot_type head;

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         fsts_cell u_cell (
            .clock, .reset, .cmd,
            .prev_slot(g == 0 ? head : slots[g == 0 ? 0 : g-1]),
            .slot(slots[g])
         );
      end
   endgenerate

   // tail wraps to head unless a free slot is being filled
   logic fill;
   always_comb begin
      head = slots[MAX_TASKS-1];
      if (fill) begin
         head.valid = 1'b1;
         head.rec   = cmd.rec;
      end
   end

   logic qdiv_start, qdiv_done;
   logic [15:0] qdiv_quot;
   // the divider samples the count at start, including a returning task counted this cycle
   fsts_divider #(.NumWidth(16), .DenWidth(CntWidth)) u_qdiv (
      .clock, .reset, .start(qdiv_start), .num(ts_ff), .den(n_in),
      .done(qdiv_done), .quot(qdiv_quot));

   fsts_pkg::slot_type tail;
   logic better;
   logic signed [6:0] nice_s;
   logic [5:0] nice_c;
   logic [32:0] sum_v, sum_r;
   logic [5:0] wgt;

   assign tail = slots[MAX_TASKS-1];
   assign better = tail.valid && (!any_ff || tail.rec.vt < best_ff.vt ||
                  (tail.rec.vt == best_ff.vt && tail.rec.order < best_ff.order));

   always_comb begin
      nice_s = {nice_ff[5], nice_ff};
      if (nice_s < -7'sd20)      nice_c = 6'h2C;
      else if (nice_s > 7'sd19) nice_c = 6'd19;
      else                       nice_c = nice_ff;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      state_in = state_ff; ictr_in = ictr_ff; run_in = run_ff; rt_in = rt_ff;
      step_in = step_ff; n_in = n_ff; any_in = any_ff; free_in = free_ff;
      minv_in = minv_ff; best_in = best_ff; back_in = back_ff; fin_in = fin_ff;
      q_in = q_ff; prod_in = prod_ff; dv_in = dv_ff;
      out_in = out_ff; outv_in = outv_ff; rsp_in = rsp_ff;
      cmd = '0; fill = 1'b0; qdiv_start = 1'b0;
      wgt = 6'(rt_ff.nice + fsts_pkg::NiceOffset);
      dv_prod = 45'(prod_ff) * 45'(fsts_pkg::NiceRecip);
      sum_v = {1'b0, rt_ff.vt} + 33'(dv_ff);
      sum_r = {1'b0, rt_ff.rt} + 33'(q_ff);
      if (outv_ff && rsp_tready) outv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            state_in = S_SCAN; step_in = '0; n_in = '0; any_in = 1'b0;
            free_in = 1'b0; back_in = 1'b0; fin_in = 1'b0;
            if (req_tuser == fsts_pkg::OpPick && run_ff) begin
               run_in = 1'b0;
               if ({16'd0, rt_ff.need} <= rt_ff.rt) fin_in = 1'b1;
               else back_in = 1'b1;
            end
         end
         S_SCAN: begin
            // one full lap: min vt, count, best, free slot
            cmd.rotate = 1'b1;
            if (tail.valid) begin
               n_in = n_ff + 1'b1;
               any_in = 1'b1;
               if (!any_ff || tail.rec.vt < minv_ff) minv_in = tail.rec.vt;
               if (better) best_in = tail.rec;
            end else free_in = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == CntWidth'(MAX_TASKS - 1))
               state_in = (op_ff == fsts_pkg::OpAdd) ? S_ADD : S_PICK;
         end
         S_ADD: begin
            out_in = '0;
            if (!free_ff) out_in[0] = 1'b1;
            else begin
               // rotate the ring until a free cell reaches the tail, fill it there
               cmd.rotate = 1'b1;
               cmd.rec = '{id: id_ff, nice: nice_c, need: need_ff,
                           vt: any_ff ? minv_ff : '0, rt: '0, order: ictr_ff};
               if (!tail.valid && !fill) fill = 1'b1;
            end
            if (!free_ff || !tail.valid) begin
               if (free_ff) ictr_in = ictr_ff + 1'b1;
               state_in = S_DONE;
               if (free_ff) begin
                  cmd.rotate = 1'b1; fill = 1'b1;
               end
            end
         end
         S_PICK: begin
            out_in = '0; out_in[34] = fin_ff; out_in[50:35] = fin_ff ? rt_ff.id : '0;
            if (back_ff) begin
               n_in = n_ff + 1'b1;
               ictr_in = ictr_ff + 1'b1;
               if (!any_ff || rt_ff.vt < best_ff.vt ||
                   (rt_ff.vt == best_ff.vt && ictr_ff < best_ff.order)) begin
                  // returning task runs again
               end else begin
                  cmd.del = 1'b1; cmd.del_order = best_ff.order;
               end
            end else if (any_ff) begin
               cmd.del = 1'b1; cmd.del_order = best_ff.order;
               rt_in = best_ff;
            end
            if (!(back_ff && !(!any_ff || rt_ff.vt < best_ff.vt ||
                  (rt_ff.vt == best_ff.vt && ictr_ff < best_ff.order)))) begin
               if (!back_ff && !any_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_DIV; qdiv_start = 1'b1;
               end
            end else begin
               // swap: delete best now, then reinsert returning task
               rt_in = best_ff;
               best_in = rt_ff; best_in.order = ictr_ff;
               state_in = S_WAITQ;
            end
         end
         S_WAITQ: begin
            // refill the freed cell with the returning task
            cmd.rotate = 1'b1;
            cmd.rec = best_ff;
            if (!tail.valid) begin
               fill = 1'b1; state_in = S_DIV; qdiv_start = 1'b1;
            end
         end
         S_DIV: if (qdiv_done) begin
            q_in = (ts_ff == '0) ? '0 : qdiv_quot;
            if (((ts_ff == '0) ? 16'd0 : qdiv_quot) < mg_ff) q_in = mg_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = 22'(q_ff) * 22'(wgt); state_in = S_DIVV;
         end
         S_DIVV: begin
            dv_in = 17'(dv_prod >> fsts_pkg::NiceRecipShift);
            state_in = S_WAITV;
         end
         S_WAITV: begin
            rt_in.vt = sum_v[32] ? fsts_pkg::Sat32 : sum_v[31:0];
            rt_in.rt = sum_r[32] ? fsts_pkg::Sat32 : sum_r[31:0];
            run_in = 1'b1;
            out_in[1] = 1'b1; out_in[17:2] = rt_ff.id; out_in[33:18] = q_ff;
            state_in = S_DONE;
         end
         // hold the result until the output register is free
         S_DONE: if (!outv_ff || rsp_tready) begin
            rsp_in = out_ff; outv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ictr_ff <= '0; run_ff <= 1'b0; rt_ff <= '0;
         outv_ff <= 1'b0; ts_ff <= fsts_pkg::ResetTimeSlice;
         mg_ff <= fsts_pkg::ResetMinGran;
      end else begin
         state_ff <= state_in; ictr_ff <= ictr_in; run_ff <= run_in;
         rt_ff <= rt_in; outv_ff <= outv_in;
         if (csr_valid && csr_index == fsts_pkg::RegTimeSlice) ts_ff <= csr_data;
         if (csr_valid && csr_index == fsts_pkg::RegMinGran)   mg_ff <= csr_data;
      end
      if (req_tvalid && req_tready) begin
         op_ff <= req_tuser; nice_ff <= req_tdata[5:0];
         need_ff <= req_tdata[21:6]; id_ff <= req_tdata[37:22];
      end
      step_ff <= step_in; n_ff <= n_in; any_ff <= any_in; free_ff <= free_in;
      minv_ff <= minv_in; best_ff <= best_in; back_ff <= back_in; fin_ff <= fin_in;
      q_ff <= q_in; prod_ff <= prod_in; dv_ff <= dv_in; out_ff <= out_in;
      rsp_ff <= rsp_in;
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed");
   a_addrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1])) else $error("mixed result");
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
module testbench;
   typedef struct packed {
      logic        op;
      logic [5:0]  nice;
      logic [15:0] need;
      logic [15:0] id;
   } sched_req_type;

   // first member lands in the highest bits
   typedef struct packed {
      logic [15:0] finished_id;
      logic        finished_valid;
      logic [15:0] quantum;
      logic [15:0] run_id;
      logic        run_valid;
      logic        add_rejected;
   } sched_rsp_type;

   typedef struct {
      logic [15:0] id;
      int          nice;
      logic [31:0] need;
      logic [31:0] vt;
      logic [31:0] rt;
      logic [31:0] order;
   } task_rec_type;

   localparam int NumSlots = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   fair_share_task_scheduler_unit DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_valid, .csr_ready,
      .csr_index, .csr_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler shadow state
   logic [15:0]  slice_ticks, min_gran;
   logic         slot_used [NumSlots];
   task_rec_type slot_task [NumSlots];
   logic [31:0]  insert_count;
   logic         cpu_busy;
   task_rec_type on_cpu;

   sched_req_type pending_reqs [$];
   sched_rsp_type expected_rsps [$];
   int            errors = 0;
   int            hold_off = 0;

   function automatic void queue_req(sched_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic bit earlier(logic [31:0] va, logic [31:0] oa,
                                  logic [31:0] vb, logic [31:0] ob);
      return va < vb || (va == vb && oa < ob);
   endfunction

   function automatic void shadow_reset();
      slice_ticks = fsts_pkg::ResetTimeSlice;
      min_gran = fsts_pkg::ResetMinGran;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      insert_count = '0;
      cpu_busy = 1'b0;
      on_cpu = '{default: '0};
   endfunction

   function automatic sched_rsp_type schedule_step(sched_req_type r);
      sched_rsp_type res;
      int            free_slot, best, n;
      bit            any, back;
      logic [31:0]   minv, q, dv;
      int            nv;
      task_rec_type  t;
      res = '0;
      free_slot = -1; best = -1; n = 0; any = 0; back = 0; minv = '0;
      if (r.op == fsts_pkg::OpAdd) begin
         for (int i = 0; i < NumSlots; i++) begin
            if (slot_used[i]) begin
               if (!any || slot_task[i].vt < minv) minv = slot_task[i].vt;
               any = 1;
            end else if (free_slot < 0) free_slot = i;
         end
         if (free_slot < 0) begin
            res.add_rejected = 1'b1;
            return res;
         end
         nv = $signed(r.nice);
         if (nv < -20) nv = -20;
         if (nv > 19) nv = 19;
         t = '{id: r.id, nice: nv, need: {16'd0, r.need}, vt: minv, rt: '0,
               order: insert_count};
         slot_used[free_slot] = 1'b1;
         slot_task[free_slot] = t;
         insert_count++;
         return res;
      end
      if (cpu_busy) begin
         if (on_cpu.rt >= on_cpu.need) begin
            res.finished_valid = 1'b1;
            res.finished_id = on_cpu.id;
         end else back = 1;
         cpu_busy = 1'b0;
      end
      for (int i = 0; i < NumSlots; i++) begin
         if (!slot_used[i]) continue;
         n++;
         if (best < 0 || earlier(slot_task[i].vt, slot_task[i].order,
                                 slot_task[best].vt, slot_task[best].order))
            best = i;
      end
      if (back) begin
         n++;
         if (best >= 0 && !earlier(on_cpu.vt, insert_count,
                                   slot_task[best].vt, slot_task[best].order)) begin
            t = on_cpu;
            t.order = insert_count;
            on_cpu = slot_task[best];
            slot_task[best] = t;
         end
         insert_count++;
      end else if (best >= 0) begin
         on_cpu = slot_task[best];
         slot_used[best] = 1'b0;
      end
      if (n == 0) return res;
      q = 32'(slice_ticks) / 32'(n);
      if (q < 32'(min_gran)) q = 32'(min_gran);
      dv = 32'((64'(q) * 64'(on_cpu.nice + 21)) / 64'd39);
      on_cpu.vt = sat_sum(on_cpu.vt, 64'(dv));
      on_cpu.rt = sat_sum(on_cpu.rt, 64'(q));
      cpu_busy = 1'b1;
      res.run_valid = 1'b1;
      res.run_id = on_cpu.id;
      res.quantum = q[15:0];
      return res;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.insert(expected_rsps.size(),
                                 schedule_step(pending_reqs.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_reqs[0].op;
               req_tdata <= {2'b00, pending_reqs[0].id, pending_reqs[0].need,
                             pending_reqs[0].nice};
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 12);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
               end
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // monitor with receiver stall pattern
   always @(posedge clock) begin
      sched_rsp_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[50:0];
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.add_rejected !== want.add_rejected)
                  $display("%0t: add_rejected expected %0d actual %0d", $time,
                           want.add_rejected, got.add_rejected);
               if (got.run_valid !== want.run_valid)
                  $display("%0t: run_valid expected %0d actual %0d", $time,
                           want.run_valid, got.run_valid);
               if (got.run_id !== want.run_id)
                  $display("%0t: run_id expected %0d actual %0d", $time,
                           want.run_id, got.run_id);
               if (got.quantum !== want.quantum)
                  $display("%0t: quantum expected %0d actual %0d", $time,
                           want.quantum, got.quantum);
               if (got.finished_valid !== want.finished_valid)
                  $display("%0t: finished_valid expected %0d actual %0d", $time,
                           want.finished_valid, got.finished_valid);
               if (got.finished_id !== want.finished_id)
                  $display("%0t: finished_id expected %0d actual %0d", $time,
                           want.finished_id, got.finished_id);
               if (got !== want) errors++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else rsp_tready <= ($urandom_range(0, 3) != 0) || ($time % 4000 < 800);
      end
   end

   task automatic write_reg(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fsts_pkg::RegTimeSlice) slice_ticks = val;
      else min_gran = val;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic sched_req_type make_req(logic op, logic [5:0] nice,
                                              logic [15:0] need, logic [15:0] id);
      sched_req_type r;
      r.op = op; r.nice = nice; r.need = need; r.id = id;
      return r;
   endfunction

   function automatic sched_req_type rand_req(int add_pct, int need_max);
      sched_req_type r;
      r.op = ($urandom_range(0, 99) < add_pct) ? fsts_pkg::OpAdd : fsts_pkg::OpPick;
      r.nice = 6'($urandom());
      r.need = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                            : 16'($urandom_range(0, need_max));
      r.id = 16'($urandom());
      return r;
   endfunction

   initial begin
      shadow_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: empty pick, nice extremes, zero need, full table
      queue_req(make_req(fsts_pkg::OpPick, 6'd0, 16'd0, 16'd0));
      queue_req(make_req(fsts_pkg::OpAdd, 6'h20, 16'hFFFF, 16'hFFFF));
      queue_req(make_req(fsts_pkg::OpAdd, 6'h1F, 16'd0, 16'd0));
      queue_req(make_req(fsts_pkg::OpAdd, 6'd19, 16'd5, 16'h1234));
      queue_req(make_req(fsts_pkg::OpAdd, 6'h2C, 16'd100, 16'hABCD));
      for (int i = 0; i < 14; i++)
         queue_req(make_req(fsts_pkg::OpAdd, 6'(i), 16'(i * 300), 16'(100 + i)));
      for (int i = 0; i < 5; i++)
         queue_req(make_req(fsts_pkg::OpPick, 6'd0, 16'd0, 16'd0));
      wait_idle();
      write_reg(fsts_pkg::RegTimeSlice, 16'd0);
      write_reg(fsts_pkg::RegMinGran, 16'd0);
      for (int i = 0; i < 20; i++) queue_req(rand_req(30, 3000));
      wait_idle();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(fsts_pkg::RegTimeSlice, 16'hFFFF);
               write_reg(fsts_pkg::RegMinGran, 16'd1);
            end
            1: begin
               write_reg(fsts_pkg::RegTimeSlice, 16'd1);
               write_reg(fsts_pkg::RegMinGran, 16'hFFFF);
            end
            2: begin
               write_reg(fsts_pkg::RegTimeSlice, 16'd2000);
               write_reg(fsts_pkg::RegMinGran, 16'd4);
            end
            default: begin
               write_reg(fsts_pkg::RegTimeSlice, 16'($urandom_range(1, 65535)));
               write_reg(fsts_pkg::RegMinGran, 16'($urandom_range(0, 300)));
            end
         endcase
         for (int i = 0; i < 180; i++) queue_req(rand_req(45, 4000));
         if (ph == 2) begin
            // long receiver hold-off while items keep coming
            while (pending_reqs.size() > 150) @(posedge clock);
            hold_off = 3000;
         end
         wait_idle();
      end
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
